@@ design/pppq_pkg.sv @@
// Package of the pending packet queue: payload words, entry layout, codes and defaults.
// Used by every file of the design folder; depends on nothing.
package pppq_pkg;

	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int CNT_W = 6;
	localparam int PADDR_W = 3;
	localparam logic [31:0] MAX_AGE_RST = 32'd3000;

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_VERDICT = 2'd1,
		ACT_COLLECT = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		VRD_SEND = 2'd0,
		VRD_ENCAP = 2'd1,
		VRD_DROP = 2'd2,
		VRD_NONE = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		RES_FWD = 2'd0,
		RES_ERR = 2'd1,
		RES_SUMMARY = 2'd2,
		RES_UNUSED = 2'd3
	} res_kind_t;

	localparam logic REG_MAX_AGE = 1'b0;
	localparam logic REG_LINK_MODE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVICT_RD,
		ST_EVICT,
		ST_PRIME,
		ST_SCAN,
		ST_SUMMARY
	} state_t;

	typedef struct packed {
		logic [1:0] action;
		logic [15:0] packet_handle;
		logic [31:0] dst_addr;
		logic is_ipv4;
		logic [1:0] verdict_kind;
		logic route_present;
		logic [31:0] now;
	} req_word_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [15:0] packet_handle_res;
		logic [4:0] send_slot;
		logic encapsulate;
		logic [5:0] released_count;
		logic status;
		logic last;
	} rsp_word_t;

	typedef struct packed {
		logic [15:0] handle;
		logic [31:0] dest;
		logic [31:0] stamp;
		logic ipv4;
	} entry_t;

endpackage

@@ design/pppq_mem.sv @@
// Entry memory of the pending packet queue: one write port, one read port, registered read.
// Depends on pppq_pkg for the entry layout.
module pppq_mem #(
	parameter int DEPTH = pppq_pkg::QUEUE_DEPTH_DEF,
	parameter int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic clk,
	input  logic we,
	input  logic [IW-1:0] waddr,
	input  pppq_pkg::entry_t wdata,
	input  logic [IW-1:0] raddr,
	output pppq_pkg::entry_t rdata
);

	pppq_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/pending_packet_queue_by_destination.sv @@
// Top level of the pending packet queue: APB registers, sequencer and output register.
// Depends on pppq_pkg and pppq_mem.
//
// Packets are held in a circular buffer in one memory. When an add finds the queue full, the
// oldest word is evicted. A verdict or a collect reads the queue through the single read port
// of the entry memory one entry a cycle, except that a removed entry waits while the output
// register is full, and writes kept entries back compacted. With nothing to act on it skips the read.
// Every action ends with a summary word. No clearing pass is needed after reset.
module pending_packet_queue_by_destination #(
	parameter int QUEUE_DEPTH = pppq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  pppq_pkg::req_word_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output pppq_pkg::rsp_word_t rsp,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [pppq_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = pppq_pkg::CNT_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	function automatic logic [IW-1:0] wrap(input logic [IW-1:0] base, input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = {{(CW+1-IW){1'b0}}, base} + {1'b0, off};
		if (sum >= {1'b0, DEPTH_C}) begin
			sum = sum - {1'b0, DEPTH_C};
		end
		return sum[IW-1:0];
	endfunction

	logic [31:0] max_age_q;
	logic link_mode_q;
	pppq_pkg::state_t state_q, state_d;
	pppq_pkg::req_word_t req_q;
	logic [IW-1:0] head_q;
	logic [CW-1:0] len_q, idx_q, keep_q, removed_q;
	logic [4:0] slot_q;
	logic status_q;
	logic rsp_valid_q;
	pppq_pkg::rsp_word_t rsp_q;

	logic mem_we;
	logic [IW-1:0] mem_waddr, mem_raddr;
	pppq_pkg::entry_t mem_wdata, mem_rdata;

	logic out_free, emit, hit, advance, scan_done, is_full;
	pppq_pkg::rsp_word_t emit_word;
	pppq_pkg::entry_t new_entry;

	pppq_mem #(.DEPTH(QUEUE_DEPTH), .IW(IW)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	assign pready = 1'b1;
	assign prdata = (paddr[2] == pppq_pkg::REG_LINK_MODE) ? {31'd0, link_mode_q} : max_age_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= pppq_pkg::MAX_AGE_RST;
			link_mode_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == pppq_pkg::REG_LINK_MODE) begin
				link_mode_q <= pwdata[0];
			end else begin
				max_age_q <= pwdata;
			end
		end
	end

	assign req_ready = (state_q == pppq_pkg::ST_IDLE);
	assign out_free = !rsp_valid_q || rsp_ready;
	assign is_full = (len_q >= DEPTH_C);
	assign new_entry = '{handle: req_q.packet_handle, dest: req_q.dst_addr,
		stamp: req_q.now, ipv4: req_q.is_ipv4};

	always_comb begin
		if (req_q.action == pppq_pkg::ACT_VERDICT) begin
			hit = (mem_rdata.dest == req_q.dst_addr);
		end else begin
			hit = ((req_q.now - mem_rdata.stamp) > max_age_q);
		end
	end
	assign advance = !hit || out_free;
	assign scan_done = ((idx_q + CW'(1)) >= len_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pppq_pkg::ST_IDLE: begin
				if (req_valid) begin
					unique case (req.action)
						pppq_pkg::ACT_ADD: begin
							state_d = is_full ? pppq_pkg::ST_EVICT_RD : pppq_pkg::ST_SUMMARY;
						end
						pppq_pkg::ACT_VERDICT: begin
							if (req.verdict_kind == pppq_pkg::VRD_NONE || len_q == '0 ||
								(req.verdict_kind == pppq_pkg::VRD_SEND && !req.route_present)) begin
								state_d = pppq_pkg::ST_SUMMARY;
							end else begin
								state_d = pppq_pkg::ST_PRIME;
							end
						end
						pppq_pkg::ACT_COLLECT: begin
							state_d = (len_q == '0) ? pppq_pkg::ST_SUMMARY : pppq_pkg::ST_PRIME;
						end
						default: state_d = pppq_pkg::ST_SUMMARY;
					endcase
				end
			end
			pppq_pkg::ST_EVICT_RD: state_d = pppq_pkg::ST_EVICT;
			pppq_pkg::ST_EVICT: if (out_free) state_d = pppq_pkg::ST_SUMMARY;
			pppq_pkg::ST_PRIME: state_d = pppq_pkg::ST_SCAN;
			pppq_pkg::ST_SCAN: if (advance && scan_done) state_d = pppq_pkg::ST_SUMMARY;
			pppq_pkg::ST_SUMMARY: if (out_free) state_d = pppq_pkg::ST_IDLE;
			default: state_d = pppq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = head_q;
		mem_wdata = new_entry;
		mem_raddr = head_q;
		emit = 1'b0;
		emit_word = '0;
		unique case (state_q)
			pppq_pkg::ST_IDLE: begin
				mem_waddr = wrap(head_q, len_q);
				mem_wdata = '{handle: req.packet_handle, dest: req.dst_addr,
					stamp: req.now, ipv4: req.is_ipv4};
				mem_we = req_valid && req.action == pppq_pkg::ACT_ADD && !is_full;
			end
			pppq_pkg::ST_EVICT: begin
				mem_we = out_free;
				emit = out_free;
				emit_word.kind = pppq_pkg::RES_ERR;
				emit_word.packet_handle_res = mem_rdata.handle;
			end
			pppq_pkg::ST_SCAN: begin
				mem_raddr = wrap(head_q, advance ? idx_q + CW'(1) : idx_q);
				mem_waddr = wrap(head_q, keep_q);
				mem_wdata = mem_rdata;
				mem_we = !hit;
				emit = hit && out_free;
				emit_word.packet_handle_res = mem_rdata.handle;
				if (req_q.action == pppq_pkg::ACT_VERDICT &&
					(req_q.verdict_kind == pppq_pkg::VRD_SEND ||
					(req_q.verdict_kind == pppq_pkg::VRD_ENCAP && !link_mode_q &&
					mem_rdata.ipv4))) begin
					emit_word.kind = pppq_pkg::RES_FWD;
					emit_word.send_slot = slot_q;
					emit_word.encapsulate = (req_q.verdict_kind == pppq_pkg::VRD_ENCAP);
				end else begin
					emit_word.kind = pppq_pkg::RES_ERR;
				end
			end
			pppq_pkg::ST_SUMMARY: begin
				emit = out_free;
				emit_word.kind = pppq_pkg::RES_SUMMARY;
				emit_word.released_count = removed_q;
				emit_word.status = status_q;
				emit_word.last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pppq_pkg::ST_IDLE;
			head_q <= '0;
			len_q <= '0;
			idx_q <= '0;
			keep_q <= '0;
			removed_q <= '0;
			slot_q <= '0;
			status_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				pppq_pkg::ST_IDLE: begin
					idx_q <= '0;
					keep_q <= '0;
					removed_q <= '0;
					slot_q <= '0;
					status_q <= req.action == pppq_pkg::ACT_VERDICT &&
						req.verdict_kind == pppq_pkg::VRD_SEND && !req.route_present;
					if (req_valid && req.action == pppq_pkg::ACT_ADD && !is_full) begin
						len_q <= len_q + CW'(1);
					end
				end
				pppq_pkg::ST_EVICT: begin
					if (out_free) begin
						head_q <= wrap(head_q, CW'(1));
						removed_q <= CW'(1);
					end
				end
				pppq_pkg::ST_SCAN: begin
					if (advance) begin
						idx_q <= idx_q + CW'(1);
						if (hit) begin
							removed_q <= removed_q + CW'(1);
							if (emit_word.kind == pppq_pkg::RES_FWD) begin
								slot_q <= slot_q + 5'd1;
							end
						end else begin
							keep_q <= keep_q + CW'(1);
						end
						if (scan_done) begin
							len_q <= hit ? keep_q : keep_q + CW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (emit) begin
			rsp_q <= emit_word;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

@@ design/pppq_checker.sv @@
// Port-level checker of the pending packet queue and its bind to the top level.
// Depends on pppq_pkg.
module pppq_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  pppq_pkg::rsp_word_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("Result word changed while stalled.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("New word taken while an action is in progress.");

	a_last_is_summary: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.last == (rsp.kind == pppq_pkg::RES_SUMMARY)))
		else $error("Last flag does not mark the summary word.");

	a_packet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind != pppq_pkg::RES_SUMMARY |-> rsp.released_count == '0 && !rsp.status)
		else $error("Packet word carries summary fields.");

endmodule

bind pending_packet_queue_by_destination pppq_checker u_pppq_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
	.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
